// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; NO_ASSERTIONS drops them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Trit encoding, operation codes and per-trit helper functions.
// ----------------------------------------------------------------------------
package bta_pkg;

    // one trit as a signed pair: 00 zero, 01 plus one, 11 minus one
    typedef logic signed [1:0] trit_t;

    localparam trit_t T_ZERO = 2'sb00;
    localparam trit_t T_POS  = 2'sb01;
    localparam trit_t T_NEG  = 2'sb11;

    // operation codes
    localparam logic [4:0] K_ADD  = 5'd0;
    localparam logic [4:0] K_SUB  = 5'd1;
    localparam logic [4:0] K_XOR  = 5'd2;
    localparam logic [4:0] K_XOR1 = 5'd3;
    localparam logic [4:0] K_XORT = 5'd4;
    localparam logic [4:0] K_OR   = 5'd5;
    localparam logic [4:0] K_OR1  = 5'd6;
    localparam logic [4:0] K_ORT  = 5'd7;
    localparam logic [4:0] K_AND  = 5'd8;
    localparam logic [4:0] K_AND1 = 5'd9;
    localparam logic [4:0] K_ANDT = 5'd10;
    localparam logic [4:0] K_SLL  = 5'd11;
    localparam logic [4:0] K_SRL  = 5'd12;
    localparam logic [4:0] K_SEQ  = 5'd13;
    localparam logic [4:0] K_SNE  = 5'd14;
    localparam logic [4:0] K_SLT  = 5'd15;
    localparam logic [4:0] K_MUL  = 5'd16;
    localparam logic [4:0] K_MULH = 5'd17;

    // low trits that hold any shift amount up to the clamp limit
    localparam int SHAMT_TRITS = 4;
    // width of a signed shift amount
    localparam int SHAMT_W = 7;

    // map the unused code 10 to zero
    function automatic trit_t trit_norm(logic [1:0] code);
        return trit_t'({code[1] & code[0], code[0]});
    endfunction

    // full add of three trits: returns {carry, sum}
    function automatic logic [3:0] trit_fa(trit_t x, trit_t y, trit_t c);
        logic signed [2:0] s;
        s = {x[1], x} + {y[1], y} + {c[1], c};
        if (s > 3'sd1)
            return {T_POS, 2'(s - 3'sd3)};
        else if (s < -3'sd1)
            return {T_NEG, 2'(s + 3'sd3)};
        else
            return {T_ZERO, 2'(s)};
    endfunction

    function automatic trit_t trit_mul(trit_t x, trit_t y);
        if (x == T_ZERO || y == T_ZERO)
            return T_ZERO;
        else if (x == y)
            return T_POS;
        else
            return T_NEG;
    endfunction

    // priority chain: hi wins, then mid, else lo
    function automatic trit_t trit_chain(trit_t lo, trit_t mid, trit_t hi,
                                         trit_t x, trit_t y);
        if (x == hi || y == hi)
            return hi;
        else if (x == mid || y == mid)
            return mid;
        else
            return lo;
    endfunction

    function automatic trit_t trit_logic(logic [4:0] k, trit_t x, trit_t y);
        trit_t r;
        r = T_ZERO;
        case (k)
            K_XOR:
            begin
                if (x == T_ZERO)
                    r = y;
                else if (y == T_ZERO)
                    r = x;
                else if (x == y)
                    r = -x;
                else
                    r = T_ZERO;
            end
            K_XOR1, K_XORT:
            begin
                if (x == T_ZERO)
                    r = y;
                else if (y == T_ZERO)
                    r = x;
                else if (x == y)
                    r = T_ZERO;
                else
                    r = (k == K_XOR1) ? T_POS : T_NEG;
            end
            K_OR:    r = trit_chain(T_NEG, T_ZERO, T_POS, x, y);
            K_OR1:   r = trit_chain(T_ZERO, T_NEG, T_POS, x, y);
            K_ORT:   r = trit_chain(T_ZERO, T_POS, T_NEG, x, y);
            K_AND:   r = trit_chain(T_POS, T_ZERO, T_NEG, x, y);
            K_AND1:  r = trit_chain(T_POS, T_NEG, T_ZERO, x, y);
            default: r = trit_chain(T_NEG, T_POS, T_ZERO, x, y);
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/bta_tadd.sv =====
// ----------------------------------------------------------------------------
// bta_tadd
// Ripple adder over packed balanced-ternary words; the final carry drops.
// ----------------------------------------------------------------------------
module bta_tadd #(
    parameter int TRITS = 18
) (
    input  logic [2*TRITS-1:0] x,
    input  logic [2*TRITS-1:0] y,
    output logic [2*TRITS-1:0] sum
);

    // ripple the carry from trit 0 upward
    always_comb
    begin
        bta_pkg::trit_t carry;
        logic [3:0]     fa;
        carry = bta_pkg::T_ZERO;
        sum   = '0;
        for (int i = 0; i < TRITS; i++)
        begin
            fa = bta_pkg::trit_fa(bta_pkg::trit_t'(x[2*i +: 2]),
                                  bta_pkg::trit_t'(y[2*i +: 2]), carry);
            sum[2*i +: 2] = fa[1:0];
            carry         = bta_pkg::trit_t'(fa[3:2]);
        end
    end

endmodule

// ===== hdl/balanced_ternary_alu.sv =====
// ----------------------------------------------------------------------------
// balanced_ternary_alu
// Pipelined execute unit for a balanced-ternary CPU word.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind, form, operand_a, operand_b and immediate with start high;
//   the word is taken at that clock edge (busy stays low, so every start
//   is taken). One word may be issued in every cycle.
//   The result word appears on result and written for exactly one cycle,
//   marked by done, after the input register, the first stage, the
//   multiply stages and the output register. Results leave in issue
//   order.
//   Throughput: one word per cycle. Latency is set by the multiplier,
//   which adds one partial product per stage over WORD_TRITS stages;
//   every operation runs through the same stages so order is kept.
//   Stage plan: input register, first add / logic / compare, WORD_TRITS
//   multiply stages (shift clamp and barrel shift ride in the first two),
//   then the final addend and output register.
//   Reset clears every valid bit; no done pulse follows until new words
//   reach the end of the pipeline. The receiver cannot stall: results are
//   shown once and must be taken.
// ----------------------------------------------------------------------------
module balanced_ternary_alu #(
    parameter int WORD_TRITS = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [4:0]              kind,
    input  logic                    form,
    input  logic [2*WORD_TRITS-1:0] operand_a,
    input  logic [2*WORD_TRITS-1:0] operand_b,
    input  logic [11:0]             immediate,
    output logic                    done,
    output logic [2*WORD_TRITS-1:0] result,
    output logic                    written
);

`include "assert_macros.svh"

    localparam int W   = 2 * WORD_TRITS;
    localparam int LAT = WORD_TRITS + 3;
    localparam logic signed [bta_pkg::SHAMT_W-1:0] NS = bta_pkg::SHAMT_W'(WORD_TRITS);

    typedef struct packed {
        logic [4:0]                          kind;
        logic                                written;
        logic                                addend_en;
        logic [5:0]                          imm3;
        logic [W-1:0]                        a;
        logic [W-1:0]                        b;
        logic [W-1:0]                        res;
        logic [2*W-1:0]                      acc;
        logic signed [bta_pkg::SHAMT_W-1:0]  shamt;
    } stage_t;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // input register, codes normalized
    // ------------------------------------------------------------------
    logic         v0_reg;
    logic [4:0]   kind0_reg;
    logic         form0_reg;
    logic [W-1:0] a0_reg;
    logic [W-1:0] b0_reg;
    logic [11:0]  imm0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        kind0_reg <= kind;
        form0_reg <= form;
        for (int i = 0; i < WORD_TRITS; i++)
        begin
            a0_reg[2*i +: 2] <= bta_pkg::trit_norm(operand_a[2*i +: 2]);
            b0_reg[2*i +: 2] <= bta_pkg::trit_norm(operand_b[2*i +: 2]);
        end
        for (int i = 0; i < 6; i++)
            imm0_reg[2*i +: 2] <= bta_pkg::trit_norm(immediate[2*i +: 2]);
    end

    // ------------------------------------------------------------------
    // first stage: add / sub / shift amount, logic, compare
    // ------------------------------------------------------------------
    logic [W-1:0] imm3w;
    logic [W-1:0] imm6w;
    logic [W-1:0] yw;
    logic [W-1:0] negb;
    logic [W-1:0] add_x;
    logic [W-1:0] add_y;
    logic [W-1:0] add_s;
    logic         is_shift0;

    always_comb
    begin
        imm3w        = '0;
        imm6w        = '0;
        imm3w[5:0]   = imm0_reg[5:0];
        imm6w[11:0]  = imm0_reg;
        yw           = form0_reg ? imm6w : b0_reg;
        for (int i = 0; i < WORD_TRITS; i++)
            negb[2*i +: 2] = -bta_pkg::trit_t'(b0_reg[2*i +: 2]);
        is_shift0 = (kind0_reg == bta_pkg::K_SLL) || (kind0_reg == bta_pkg::K_SRL);
        // shift amount is b + imm3 or the bare immediate
        if (is_shift0)
        begin
            add_x = form0_reg ? '0 : b0_reg;
            add_y = form0_reg ? yw : imm3w;
        end
        else
        begin
            add_x = a0_reg;
            add_y = (kind0_reg == bta_pkg::K_SUB) ? negb : yw;
        end
    end

    bta_tadd #(.TRITS(WORD_TRITS)) u_add1 (
        .x   (add_x),
        .y   (add_y),
        .sum (add_s)
    );

    stage_t       s1_next;
    stage_t       stg_reg [WORD_TRITS+1];
    stage_t       stg_next [WORD_TRITS];
    logic [WORD_TRITS:0] vld_reg;

    always_comb
    begin
        logic [W-1:0] lg;
        logic         lt;
        logic         eq;
        bta_pkg::trit_t ta;
        bta_pkg::trit_t ty;
        // tritwise logic over the word, then (register form only) low three trits against imm3
        for (int i = 0; i < WORD_TRITS; i++)
            lg[2*i +: 2] = bta_pkg::trit_logic(kind0_reg,
                bta_pkg::trit_t'(a0_reg[2*i +: 2]), bta_pkg::trit_t'(yw[2*i +: 2]));
        if (!form0_reg)
            for (int i = 0; i < 3; i++)
                lg[2*i +: 2] = bta_pkg::trit_logic(kind0_reg,
                    bta_pkg::trit_t'(lg[2*i +: 2]), bta_pkg::trit_t'(imm0_reg[2*i +: 2]));
        // signed compare: highest differing trit decides
        eq = (a0_reg == yw);
        lt = 1'b0;
        for (int i = 0; i < WORD_TRITS; i++)
        begin
            ta = bta_pkg::trit_t'(a0_reg[2*i +: 2]);
            ty = bta_pkg::trit_t'(yw[2*i +: 2]);
            if (ta != ty)
                lt = (ta < ty);
        end

        s1_next.kind      = kind0_reg;
        s1_next.imm3      = imm0_reg[5:0];
        s1_next.a         = a0_reg;
        s1_next.b         = b0_reg;
        s1_next.acc       = '0;
        s1_next.shamt     = '0;
        s1_next.res       = '0;
        s1_next.written   = 1'b1;
        s1_next.addend_en = 1'b0;
        case (kind0_reg)
            bta_pkg::K_ADD:
            begin
                s1_next.res       = add_s;
                s1_next.addend_en = !form0_reg;
            end
            bta_pkg::K_SUB:
            begin
                s1_next.res       = add_s;
                s1_next.written   = !form0_reg;
                s1_next.addend_en = !form0_reg;
            end
            bta_pkg::K_XOR, bta_pkg::K_XOR1, bta_pkg::K_XORT,
            bta_pkg::K_OR, bta_pkg::K_OR1, bta_pkg::K_ORT,
            bta_pkg::K_AND, bta_pkg::K_AND1, bta_pkg::K_ANDT:
                s1_next.res = lg;
            bta_pkg::K_SLL, bta_pkg::K_SRL:
                s1_next.res = add_s;
            bta_pkg::K_SEQ:
                s1_next.res[1:0] = eq ? bta_pkg::T_POS : bta_pkg::T_ZERO;
            bta_pkg::K_SNE:
                s1_next.res[1:0] = eq ? bta_pkg::T_ZERO : bta_pkg::T_POS;
            bta_pkg::K_SLT:
                s1_next.res[1:0] = lt ? bta_pkg::T_POS : bta_pkg::T_ZERO;
            bta_pkg::K_MUL, bta_pkg::K_MULH:
            begin
                s1_next.written   = !form0_reg;
                s1_next.addend_en = !form0_reg;
            end
            default:
                s1_next.written = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // multiply stages: one partial product each; shift rides in 0 and 1
    // ------------------------------------------------------------------
    for (genvar j = 0; j < WORD_TRITS; j++)
    begin : g_mul
        logic [2*W-1:0] pp;
        logic [2*W-1:0] acc_sum;

        // form a times trit j of b, placed at trit j
        always_comb
        begin
            pp = '0;
            for (int k = 0; k < WORD_TRITS; k++)
                pp[2*(k+j) +: 2] = bta_pkg::trit_mul(
                    bta_pkg::trit_t'(stg_reg[j].a[2*k +: 2]),
                    bta_pkg::trit_t'(stg_reg[j].b[2*j +: 2]));
        end

        bta_tadd #(.TRITS(2*WORD_TRITS)) u_acc (
            .x   (stg_reg[j].acc),
            .y   (pp),
            .sum (acc_sum)
        );

        always_comb
        begin
            logic                                is_shift;
            logic                                is_mul;
            bta_pkg::trit_t                      sgn;
            bta_pkg::trit_t                      tt;
            logic signed [bta_pkg::SHAMT_W-1:0]  tw [bta_pkg::SHAMT_TRITS];
            logic signed [bta_pkg::SHAMT_W-1:0]  v;
            logic signed [bta_pkg::SHAMT_W-1:0]  s;
            logic [bta_pkg::SHAMT_W-1:0]         mag;

            stg_next[j] = stg_reg[j];
            is_shift = (stg_reg[j].kind == bta_pkg::K_SLL) ||
                       (stg_reg[j].kind == bta_pkg::K_SRL);
            is_mul   = (stg_reg[j].kind == bta_pkg::K_MUL) ||
                       (stg_reg[j].kind == bta_pkg::K_MULH);
            if (is_mul)
                stg_next[j].acc = acc_sum;

            // clamp the amount: any nonzero high trit saturates
            sgn = bta_pkg::T_ZERO;
            for (int i = bta_pkg::SHAMT_TRITS; i < WORD_TRITS; i++)
            begin
                tt = bta_pkg::trit_t'(stg_reg[j].res[2*i +: 2]);
                if (tt != bta_pkg::T_ZERO)
                    sgn = tt;
            end
            for (int i = 0; i < bta_pkg::SHAMT_TRITS; i++)
                tw[i] = bta_pkg::SHAMT_W'(bta_pkg::trit_t'(stg_reg[j].res[2*i +: 2]));
            v = bta_pkg::SHAMT_W'(tw[0] + 7'sd3 * tw[1] + 7'sd9 * tw[2] + 7'sd27 * tw[3]);
            if (sgn == bta_pkg::T_POS)
                s = NS;
            else if (sgn == bta_pkg::T_NEG)
                s = -NS;
            else if (v > NS)
                s = NS;
            else if (v < -NS)
                s = -NS;
            else
                s = v;
            if (stg_reg[j].kind == bta_pkg::K_SRL)
                s = -s;
            if (j == 0 && is_shift)
                stg_next[j].shamt = s;

            // barrel shift, positive amount toward high trits
            mag = stg_reg[j].shamt[bta_pkg::SHAMT_W-1] ? -stg_reg[j].shamt
                                                       : stg_reg[j].shamt;
            if (j == 1 && is_shift)
                stg_next[j].res = stg_reg[j].shamt[bta_pkg::SHAMT_W-1]
                                ? stg_reg[j].a >> {mag, 1'b0}
                                : stg_reg[j].a << {mag, 1'b0};
        end
    end

    // advance the pipeline every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[WORD_TRITS-1:0], v0_reg};
    end

    always_ff @(posedge clk)
    begin
        stg_reg[0] <= s1_next;
        for (int j = 0; j < WORD_TRITS; j++)
            stg_reg[j+1] <= stg_next[j];
    end

    // ------------------------------------------------------------------
    // final stage: pick the word, add imm3 when enabled, register the output
    // ------------------------------------------------------------------
    stage_t       fin;
    logic [W-1:0] sel;
    logic [W-1:0] addend;
    logic [W-1:0] fin_sum;
    logic         done_reg;
    logic [W-1:0] result_reg;
    logic         written_reg;

    assign fin = stg_reg[WORD_TRITS];

    always_comb
    begin
        case (fin.kind)
            bta_pkg::K_MUL:  sel = fin.acc[W-1:0];
            bta_pkg::K_MULH: sel = fin.acc[2*W-1:W];
            default:         sel = fin.res;
        endcase
        addend = '0;
        if (fin.addend_en)
            addend[5:0] = fin.imm3;
    end

    bta_tadd #(.TRITS(WORD_TRITS)) u_fin (
        .x   (sel),
        .y   (addend),
        .sum (fin_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[WORD_TRITS];
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= fin.written ? fin_sum : '0;
        written_reg <= fin.written;
    end

    assign done    = done_reg;
    assign result  = result_reg;
    assign written = written_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_issue_done, clk, rst_n, start, ##LAT done)
    `ASSERT_IMPL(a_done_issue, clk, rst_n, done, $past(start, LAT))
    `ASSERT_IMPL(a_unwritten_zero, clk, rst_n, done && !written, result == '0)
    `ASSERT_NEXT(a_valid_moves, clk, rst_n, vld_reg[0], vld_reg[1])

endmodule
